>>> design/espc_pkg.sv
`default_nettype none

package espc_pkg;

    localparam int PRICE_PORT_W = 8;
    localparam int MAX_ITEMS    = 32;
    localparam int PRICE_BITS   = 8;
    localparam int PRICE_MASK   = (1 << PRICE_BITS) - 1;
    localparam int HALF_LIMIT   = (MAX_ITEMS * PRICE_MASK) / 2;
    localparam int WORD_BITS    = 64;
    localparam int SEL_W        = 6;
    localparam int SUM_WORDS    = HALF_LIMIT / WORD_BITS + 1;
    localparam int ADDR_W       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int TOTAL_W      = $clog2(MAX_ITEMS * PRICE_MASK + 1);
    localparam int COUNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W        = (ADDR_W + 1 > PRICE_BITS) ? ADDR_W + 1 : PRICE_BITS;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = 1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  merge;
        logic                  last;
        logic                  ovf;
        logic [TOTAL_W-1:0]    total;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_DRAIN,
        BK_LOOKUP,
        BK_FETCH
    } back_state_t;

endpackage

`default_nettype wire

>>> design/espc_ram.sv
`default_nettype none

module espc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re_a,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic             re_b,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (re_b) begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> design/espc_front.sv
`default_nettype none

module espc_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [espc_pkg::PRICE_PORT_W-1:0] s_price,
    input  wire logic                              s_last_item,
    output logic                                   q_valid,
    input  wire logic                              q_ready,
    output espc_pkg::cmd_t                         q_cmd
);

    import espc_pkg::*;

    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  ovf_reg, ovf_next;
    logic [PRICE_BITS-1:0] price;
    logic                  full;
    logic                  accept;

    assign price   = PRICE_BITS'(s_price);
    assign full    = count_reg >= COUNT_W'(MAX_ITEMS);
    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign accept  = s_valid && q_ready;

    always_comb begin
        q_cmd.price = price;
        q_cmd.merge = !ovf_reg && !full;
        q_cmd.last  = s_last_item;
        q_cmd.ovf   = ovf_reg || full;
        q_cmd.total = q_cmd.merge ? total_reg + TOTAL_W'(price) : total_reg;
    end

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_last_item) begin
                count_next = '0;
                total_next = '0;
                ovf_next   = 1'b0;
            end else begin
                count_next = q_cmd.merge ? count_reg + COUNT_W'(1) : count_reg;
                total_next = q_cmd.total;
                ovf_next   = q_cmd.ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> design/espc_fifo.sv
`default_nettype none

module espc_fifo (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  espc_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  wire logic      pop,
    output espc_pkg::cmd_t pop_cmd
);

    import espc_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != (FIFO_PTR_W + 1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_PTR_W + 1)'(do_push) - (FIFO_PTR_W + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/espc_back.sv
`default_nettype none

module espc_back (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cmd_valid,
    output logic           cmd_pop,
    input  espc_pkg::cmd_t cmd,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic           m_splittable,
    output logic           m_too_many_items
);

    import espc_pkg::*;

    back_state_t state_reg, state_next;

    logic [ADDR_W:0]       cnt_reg, cnt_next;
    word_t                 prev_b_reg, prev_b_next;
    logic                  d_vld_reg, d_word_reg, d_bok_reg;
    logic [ADDR_W-1:0]     d_w_reg;
    logic                  a_vld_reg, a_zero_reg, b_vld_reg, b_zero_reg;
    logic [SUM_WORDS-1:0]  vld_reg;
    logic                  m_valid_reg, m_split_reg, m_tmi_reg;

    logic                  issue, lookup_rd, load_res, clear_vld, out_free;
    logic [PRICE_BITS-1:0] q;
    logic [SEL_W-1:0]      r;
    logic                  cnt_is_word;
    logic                  b_ok;
    logic [CMP_W-1:0]      b_diff;
    logic [ADDR_W-1:0]     a_addr, b_addr;
    logic                  re_a, re_b;
    word_t                 rdata_a, rdata_b;
    word_t                 a_eff, b_eff, cur_b, add;
    logic [2*WORD_BITS-1:0] wide;
    logic                  ram_we;
    word_t                 wdata;
    logic [TOTAL_W-1:0]    half;
    logic [ADDR_W-1:0]     half_word;
    logic [SEL_W-1:0]      half_sel;
    logic                  ok;

    assign q           = cmd.price >> SEL_W;
    assign r           = SEL_W'(cmd.price);
    assign cnt_is_word = cnt_reg < (ADDR_W + 1)'(SUM_WORDS);
    assign b_ok        = CMP_W'(cnt_reg) > CMP_W'(q);
    assign b_diff      = CMP_W'(cnt_reg) - CMP_W'(q) - CMP_W'(1);
    assign b_addr      = b_diff[ADDR_W-1:0];
    assign half        = cmd.total >> 1;
    assign half_word   = ADDR_W'(half >> SEL_W);
    assign half_sel    = SEL_W'(half);
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.merge) begin
                        state_next = BK_SWEEP;
                    end else if (cmd.last) begin
                        state_next = BK_LOOKUP;
                    end
                end
            end
            BK_SWEEP: begin
                if (cnt_reg == '0) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                state_next = cmd.last ? BK_LOOKUP : BK_IDLE;
            end
            BK_LOOKUP: begin
                state_next = BK_FETCH;
            end
            BK_FETCH: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        issue     = 1'b0;
        lookup_rd = 1'b0;
        load_res  = 1'b0;
        clear_vld = 1'b0;
        cmd_pop   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                cmd_pop = cmd_valid && !cmd.merge && !cmd.last;
            end
            BK_SWEEP: begin
                issue = 1'b1;
            end
            BK_DRAIN: begin
                cmd_pop = !cmd.last;
            end
            BK_LOOKUP: begin
                lookup_rd = 1'b1;
            end
            BK_FETCH: begin
                load_res  = out_free;
                clear_vld = out_free;
                cmd_pop   = out_free;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == BK_IDLE) begin
            cnt_next = (ADDR_W + 1)'(SUM_WORDS);
        end else if (issue) begin
            cnt_next = cnt_reg - (ADDR_W + 1)'(1);
        end
    end

    assign a_addr = lookup_rd ? half_word : cnt_reg[ADDR_W-1:0];
    assign re_a   = (issue && cnt_is_word) || lookup_rd;
    assign re_b   = issue && b_ok;

    espc_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(SUM_WORDS)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (d_w_reg),
        .wdata  (wdata),
        .re_a   (re_a),
        .raddr_a(a_addr),
        .rdata_a(rdata_a),
        .re_b   (re_b),
        .raddr_b(b_addr),
        .rdata_b(rdata_b)
    );

    always_comb begin
        a_eff = a_vld_reg ? rdata_a : (a_zero_reg ? WORD_BITS'(1) : '0);
        b_eff = b_vld_reg ? rdata_b : (b_zero_reg ? WORD_BITS'(1) : '0);
        cur_b = d_bok_reg ? b_eff : '0;
        wide  = {prev_b_reg, cur_b} << r;
        add   = wide[2*WORD_BITS-1:WORD_BITS];
        wdata = a_eff | add;
        ram_we      = d_vld_reg && d_word_reg;
        prev_b_next = d_vld_reg ? cur_b : prev_b_reg;
        ok = !cmd.ovf && !cmd.total[0] && a_eff[half_sel];
    end

    always_ff @(posedge aclk) begin
        prev_b_reg <= prev_b_next;
        d_w_reg    <= cnt_reg[ADDR_W-1:0];
        d_word_reg <= cnt_is_word;
        d_bok_reg  <= b_ok;
        if (re_a) begin
            a_vld_reg  <= vld_reg[a_addr];
            a_zero_reg <= a_addr == '0;
        end
        if (re_b) begin
            b_vld_reg  <= vld_reg[b_addr];
            b_zero_reg <= b_addr == '0;
        end
        if (load_res) begin
            m_split_reg <= ok;
            m_tmi_reg   <= cmd.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            d_vld_reg   <= 1'b0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            d_vld_reg <= issue;
            if (clear_vld) begin
                vld_reg <= '0;
            end else if (ram_we) begin
                vld_reg[d_w_reg] <= 1'b1;
            end
            if (load_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_splittable     = m_split_reg;
    assign m_too_many_items = m_tmi_reg;

`ifndef SYNTHESIS
    a_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(state_reg == BK_SWEEP))
        else $error("bitset write outside a sweep");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load_res |-> (cmd_valid && cmd.last))
        else $error("result loaded for a word that does not close a set");

    a_ovf_forces_false: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tmi_reg) |-> !m_split_reg)
        else $error("overflowed set reported splittable");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SWEEP) |-> (cnt_reg <= (ADDR_W + 1)'(SUM_WORDS)))
        else $error("sweep counter out of range");

    a_pop_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_IDLE) |-> cmd_valid)
        else $error("back end busy without a queued word");
`endif

endmodule

`default_nettype wire

>>> design/equal_sum_partition_check.sv
// Channel | Ports                                         | Direction
// s_      | s_valid s_ready s_price[7:0] s_last_item      | in,  one price per word
// m_      | m_valid m_ready m_splittable m_too_many_items | out, one word per set
//
// The front end takes a word every cycle while its two-entry queue has room.
// A price that enters the bitset passes through the back end as one dispatch,
// the issue steps (a priming read plus one 64-bit RAM word per cycle over 64 words,
// top down, on the two read ports of the bitset RAM) and one drain step.
// A price past the item limit is popped at dispatch; the last word of a set adds the
// lookup and fetch states before the result, and waits there while m_ready holds it.
// Reset is synchronous, active low, and clears the per-word valid bits at once.
`default_nettype none

module equal_sum_partition_check (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [espc_pkg::PRICE_PORT_W-1:0] s_price,
    input  wire logic                              s_last_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_splittable,
    output logic                                   m_too_many_items
);

    import espc_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;
    logic c_valid, c_pop;
    cmd_t c_cmd;

    espc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_price    (s_price),
        .s_last_item(s_last_item),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd)
    );

    espc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(q_valid),
        .push_ready(q_ready),
        .push_cmd  (q_cmd),
        .pop_valid (c_valid),
        .pop       (c_pop),
        .pop_cmd   (c_cmd)
    );

    espc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (c_valid),
        .cmd_pop         (c_pop),
        .cmd             (c_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_splittable    (m_splittable),
        .m_too_many_items(m_too_many_items)
    );

endmodule

`default_nettype wire
